@@ rtl/core/pcl_pkg.sv @@
`timescale 1ns / 1ps
// Package for the positional character list: word types, codes and cell control.
package pcl_pkg;

  localparam int unsigned RankW = 6;
  localparam int unsigned SymW  = 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_PRINT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_VALUE   = 3'd0,
    ST_OK      = 3'd1,
    ST_INVALID = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_cmd_e;

  typedef enum logic {
    PCL_IDLE,
    PCL_PRINT
  } pcl_state_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [RankW-1:0] rank;
    logic [SymW-1:0]  symbol;
  } in_word_t;

  typedef struct packed {
    logic [SymW-1:0] value;
    logic [2:0]      status;
    logic            last;
  } out_word_t;

  // Broadcast to every cell: pos is the zero-based target, tail the last occupied cell.
  typedef struct packed {
    cell_cmd_e        cmd;
    logic [RankW-1:0] pos;
    logic [RankW-1:0] tail;
    logic [SymW-1:0]  symbol;
  } cell_ctrl_t;

endpackage

@@ rtl/core/pcl_cell.sv @@
`timescale 1ns / 1ps
// One list cell: holds a symbol and trades it with its neighbors.
module pcl_cell import pcl_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  cell_ctrl_t      ctrl_i,
  input  logic [SymW-1:0] left_i,
  input  logic [SymW-1:0] right_i,
  input  logic [SymW-1:0] head_i,
  output logic [SymW-1:0] data_o,
  output logic [SymW-1:0] pick_o
);

  localparam logic [RankW-1:0] IdxC = RankW'(IDX);

  logic [SymW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.cmd)
      CELL_INSERT: begin
        if (IdxC > ctrl_i.pos) begin
          data_d = left_i;
        end else if (IdxC == ctrl_i.pos) begin
          data_d = ctrl_i.symbol;
        end
      end
      CELL_DELETE: begin
        if (IdxC >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      CELL_ROTATE: begin
        // wrap the head around to the tail
        if (IdxC < ctrl_i.tail) begin
          data_d = right_i;
        end else if (IdxC == ctrl_i.tail) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign pick_o = (IdxC == ctrl_i.pos) ? data_q : '0;

endmodule

@@ rtl/core/positional_char_list.sv @@
`timescale 1ns / 1ps
// Top level of the positional character list: a chain of symbol cells and its control.
//
// Usage:
//   Present a command word on cmd_i and raise start_i; the word is taken at a
//   rising edge where start_i is high and busy_o is low. Commands are add,
//   delete, get (by one-based rank) and print.
//   Results leave on res_o, marked by valid_o for exactly one cycle each; the
//   receiver must take them as they come, it cannot stall the block.
//   Add, delete and get finish in the accept cycle inside the cell chain and
//   give one registered result word in the cycle after acceptance; a new command may follow
//   in the very next cycle, so these run at one word per cycle.
//   Print of N elements holds busy_o high while the chain rotates its occupied
//   cells once around, giving one result per cycle from cell 0; the first word
//   passes the state register and then the result register. An empty print
//   gives a single empty-status word in the cycle after acceptance. A new
//   command is taken only once the rotation ends and busy_o falls.
//   Reset clears the element count and the control; cell contents are not
//   reset and are only read below the count.
module positional_char_list import pcl_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_word_t  cmd_i,
  output logic      busy_o,
  output logic      valid_o,
  output out_word_t res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((RankW > CntW) ? RankW : CntW) + 1;

  pcl_state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] pidx_q, pidx_d;
  logic            valid_q, valid_d;
  out_word_t       res_q, res_d;
  cell_ctrl_t      ctrl;

  logic [SymW-1:0] data_w  [CAPACITY];
  logic [SymW-1:0] pick_w  [CAPACITY];
  logic [SymW-1:0] left_w  [CAPACITY];
  logic [SymW-1:0] right_w [CAPACITY];
  logic [SymW-1:0] pick_or;

  logic            accept;
  logic [CmpW-1:0] rank_x, cnt_x;
  logic            rank_ok_rd, rank_ok_add, is_empty, is_full, print_end;

  assign accept      = start_i && (state_q == PCL_IDLE);
  assign rank_x      = CmpW'(cmd_i.rank);
  assign cnt_x       = CmpW'(count_q);
  assign rank_ok_rd  = (rank_x != '0) && (rank_x <= cnt_x);
  assign rank_ok_add = (rank_x != '0) && (rank_x <= cnt_x + CmpW'(1));
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q == CntW'(CAPACITY));
  assign print_end   = (pidx_q == count_q - CntW'(1));

  // Cell chain: each cell sees its neighbors and the head for rotation.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_mid_l
      assign left_w[g] = data_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_mid_r
      assign right_w[g] = data_w[g+1];
    end

    pcl_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left_w[g]),
      .right_i(right_w[g]),
      .head_i (data_w[0]),
      .data_o (data_w[g]),
      .pick_o (pick_w[g])
    );
  end

  // Get: only the addressed cell drives a nonzero pick.
  always_comb begin
    pick_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pick_or = pick_or | pick_w[i];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      PCL_IDLE: begin
        if (accept && (cmd_i.op == OP_PRINT) && !is_empty) begin
          state_d = PCL_PRINT;
        end
      end
      PCL_PRINT: begin
        if (print_end) begin
          state_d = PCL_IDLE;
        end
      end
      default: state_d = PCL_IDLE;
    endcase
  end

  // Outputs, cell control and count.
  always_comb begin
    ctrl.cmd    = CELL_HOLD;
    ctrl.pos    = cmd_i.rank - RankW'(1);
    ctrl.tail   = RankW'(count_q - CntW'(1));
    ctrl.symbol = cmd_i.symbol;
    count_d     = count_q;
    pidx_d      = pidx_q;
    valid_d     = 1'b0;
    res_d       = '0;
    unique case (state_q)
      PCL_IDLE: begin
        if (accept) begin
          valid_d    = 1'b1;
          res_d.last = 1'b1;
          pidx_d     = '0;
          unique case (cmd_i.op)
            OP_ADD: begin
              // empty list: rank is ignored, symbol lands in cell 0
              if (is_empty) begin
                ctrl.cmd     = CELL_INSERT;
                ctrl.pos     = '0;
                count_d      = CntW'(1);
                res_d.status = ST_OK;
              end else if (is_full) begin
                res_d.status = ST_FULL;
              end else if (!rank_ok_add) begin
                res_d.status = ST_INVALID;
              end else begin
                ctrl.cmd     = CELL_INSERT;
                count_d      = count_q + CntW'(1);
                res_d.status = ST_OK;
              end
            end
            OP_DELETE: begin
              if (rank_ok_rd) begin
                ctrl.cmd     = CELL_DELETE;
                count_d      = count_q - CntW'(1);
                res_d.status = ST_OK;
              end else begin
                res_d.status = ST_INVALID;
              end
            end
            OP_GET: begin
              if (rank_ok_rd) begin
                res_d.value  = pick_or;
                res_d.status = ST_VALUE;
              end else begin
                res_d.status = ST_INVALID;
              end
            end
            OP_PRINT: begin
              // nonempty: words come out of the print state, drop this one
              if (is_empty) begin
                res_d.status = ST_EMPTY;
              end else begin
                valid_d = 1'b0;
              end
            end
            default: res_d.status = ST_INVALID;
          endcase
        end
      end
      PCL_PRINT: begin
        ctrl.cmd     = CELL_ROTATE;
        valid_d      = 1'b1;
        res_d.value  = data_w[0];
        res_d.status = ST_VALUE;
        res_d.last   = print_end;
        pidx_d       = pidx_q + CntW'(1);
      end
      default: ctrl.cmd = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PCL_IDLE;
      count_q <= '0;
      pidx_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pidx_q  <= pidx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o  = (state_q == PCL_PRINT);
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the positional character list: command driver, predictor, checker.
module tb;
  import pcl_pkg::*;

  localparam int unsigned CAPACITY     = 32;
  localparam int unsigned RANDOM_WORDS = 145;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      start_i = 1'b0;
  in_word_t  cmd_i   = '0;
  logic      busy_o;
  logic      valid_o;
  out_word_t res_o;

  // Command words still to be sent, and result words the block still owes us.
  in_word_t    pending_words [$];
  out_word_t   expected_words [$];

  // Predicted list contents, element k at index k-1.
  logic [SymW-1:0] list_model [$];

  int unsigned idle_left;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  bit          calm_run;
  int unsigned plan_count;
  out_word_t   oldest_word;

  positional_char_list #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Push one result word onto the list of words the block owes us.
  task automatic owe_word(logic [SymW-1:0] value, status_e status, logic last);
    out_word_t w;
    w.value  = value;
    w.status = status;
    w.last   = last;
    expected_words.push_back(w);
  endtask

  // Apply one accepted command to the list model and queue the words it causes.
  task automatic apply_list_command(in_word_t w);
    int unsigned n;
    int unsigned rank;
    n    = list_model.size();
    rank = w.rank;
    case (w.op)
      OP_ADD: begin
        // An empty list takes the symbol as its only element, whatever the rank.
        if (n == 0) begin
          list_model.push_back(w.symbol);
          owe_word('0, ST_OK, 1'b1);
        end else if (n >= CAPACITY) begin
          owe_word('0, ST_FULL, 1'b1);
        end else if (rank < 1 || rank > n + 1) begin
          owe_word('0, ST_INVALID, 1'b1);
        end else begin
          list_model.insert(rank - 1, w.symbol);
          owe_word('0, ST_OK, 1'b1);
        end
      end
      OP_DELETE: begin
        if (rank >= 1 && rank <= n) begin
          list_model.delete(rank - 1);
          owe_word('0, ST_OK, 1'b1);
        end else begin
          owe_word('0, ST_INVALID, 1'b1);
        end
      end
      OP_GET: begin
        if (rank >= 1 && rank <= n) begin
          owe_word(list_model[rank - 1], ST_VALUE, 1'b1);
        end else begin
          owe_word('0, ST_INVALID, 1'b1);
        end
      end
      default: begin
        // Print: one empty word, or every element in order with last on the final one.
        if (n == 0) begin
          owe_word('0, ST_EMPTY, 1'b1);
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            owe_word(list_model[i], ST_VALUE, (i + 1 == n));
          end
        end
      end
    endcase
  endtask

  // Queue one command word and track the list length it leaves behind, so that
  // the random part can aim its ranks at positions that actually exist.
  task automatic plan_word(op_e op, int unsigned rank, int unsigned symbol);
    in_word_t w;
    w.op     = op;
    w.rank   = rank[RankW-1:0];
    w.symbol = symbol[SymW-1:0];
    pending_words.push_back(w);
    case (op)
      OP_ADD: begin
        if (plan_count == 0) begin
          plan_count = 1;
        end else if (plan_count < CAPACITY && rank >= 1 && rank <= plan_count + 1) begin
          plan_count++;
        end
      end
      OP_DELETE: begin
        if (rank >= 1 && rank <= plan_count) begin
          plan_count--;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Gap before the next word: mostly none or short, now and then long, and
  // whole stretches with no gap at all while calm_run is set.
  function automatic int unsigned draw_gap();
    int unsigned roll;
    if ($urandom_range(0, 15) == 0) begin
      calm_run = !calm_run;
    end
    roll = $urandom_range(0, 99);
    if (calm_run || roll < 45) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // Driver: predict each word at the edge that takes it, then present the next
  // one or idle. start_i gets a single assignment per edge, so a word that
  // follows directly keeps start_i high without a glitch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i   <= 1'b0;
      cmd_i     <= '0;
      idle_left <= 0;
    end else begin
      if (start_i && !busy_o) begin
        apply_list_command(cmd_i);
      end
      // Hold the current word while the block is busy; otherwise advance.
      if (!start_i || !busy_o) begin
        if (idle_left != 0) begin
          idle_left <= idle_left - 1;
          start_i   <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cmd_i     <= pending_words.pop_front();
          start_i   <= 1'b1;
          idle_left <= draw_gap();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(string what, out_word_t want, out_word_t got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%0t: %s: expected value=%02h status=%0d last=%0b, got value=%02h status=%0d last=%0b",
               $realtime, what, want.value, want.status, want.last,
               got.value, got.status, got.last);
    end
  endtask

  // Monitor: every strobed word must match the oldest one owed, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected result word", '0, res_o);
      end else begin
        oldest_word = expected_words.pop_front();
        if (res_o.value !== oldest_word.value || res_o.status !== oldest_word.status ||
            res_o.last !== oldest_word.last) begin
          note_mismatch("result word mismatch", oldest_word, res_o);
        end
      end
    end
  end

  // Watchdog: a lost result word would otherwise hang the end of the run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned n;
    int unsigned rank;
    bit          growing;
    op_e         op;

    plan_count = 0;
    calm_run   = 1'b0;
    growing    = 1'b1;

    // Directed part: empty-list cases, rank extremes, front/middle/back edits.
    plan_word(OP_PRINT,  0,  8'h3C);   // print of an empty list
    plan_word(OP_GET,    1,  8'h00);   // get on an empty list
    plan_word(OP_DELETE, 1,  8'h00);   // delete on an empty list
    plan_word(OP_ADD,    63, 8'hFF);   // add to empty list ignores the rank
    plan_word(OP_ADD,    0,  8'h00);   // rank zero is invalid on a nonempty list
    plan_word(OP_ADD,    3,  8'h11);   // one past the append position
    plan_word(OP_ADD,    1,  8'h00);   // insert at the front
    plan_word(OP_ADD,    3,  8'hA5);   // append
    plan_word(OP_ADD,    2,  8'h5A);   // insert in the middle
    plan_word(OP_GET,    1,  8'hFF);
    plan_word(OP_GET,    4,  8'h00);
    plan_word(OP_GET,    0,  8'h00);
    plan_word(OP_GET,    5,  8'h00);   // one past the end
    plan_word(OP_GET,    63, 8'h00);
    plan_word(OP_PRINT,  63, 8'hFF);
    plan_word(OP_DELETE, 2,  8'h77);   // delete in the middle
    plan_word(OP_DELETE, 0,  8'h00);
    plan_word(OP_DELETE, 4,  8'h00);   // one past the end
    plan_word(OP_DELETE, 3,  8'h00);   // delete the last element
    plan_word(OP_PRINT,  1,  8'h00);
    plan_word(OP_DELETE, 1,  8'h00);
    plan_word(OP_DELETE, 1,  8'h00);   // list is empty again
    plan_word(OP_DELETE, 1,  8'h00);
    plan_word(OP_PRINT,  0,  8'h00);
    plan_word(OP_ADD,    32, 8'h80);

    // Random part: alternate growing to full and shrinking to empty, so that
    // full and empty lists both come up, with random symbols and mostly valid
    // ranks. About one word in ten aims at a bad rank.
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      n = plan_count;
      if (growing && n == CAPACITY && $urandom_range(0, 2) == 0) begin
        growing = 1'b0;
      end else if (!growing && n == 0) begin
        growing = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (growing) begin
        op = (roll < 60) ? OP_ADD : (roll < 70) ? OP_DELETE : (roll < 85) ? OP_GET : OP_PRINT;
      end else begin
        op = (roll < 10) ? OP_ADD : (roll < 60) ? OP_DELETE : (roll < 85) ? OP_GET : OP_PRINT;
      end
      if (op == OP_PRINT || $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       rank = 0;
          1:       rank = n + 1;
          2:       rank = n + 2;
          default: rank = $urandom_range(0, 63);
        endcase
      end else if (op == OP_ADD) begin
        rank = (n == 0) ? $urandom_range(0, 63) : $urandom_range(1, n + 1);
      end else begin
        rank = (n == 0) ? $urandom_range(0, 63) : $urandom_range(1, n);
      end
      plan_word(op, rank, $urandom_range(0, 255));
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all words sent, every owed result seen, then quiet cycles to catch
    // stray strobes.
    while (pending_words.size() != 0 || start_i) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
